FILE: src/matrix_multiply_engine_core_defines.svh
// assertion macros for the matrix multiply engine checker
`ifndef MATRIX_MULTIPLY_ENGINE_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MME_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MME_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: src/mme_pkg.sv
// shared constants, types and command structs of the matrix multiply engine
package mme_pkg;

  localparam int unsigned MAX_DIM_DEF  = 8;
  localparam int unsigned ELEM_W_DEF   = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 4;
  localparam int unsigned PROD_W       = 35;
  localparam int unsigned IDX_OUT_W    = 3;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_N  = 2'd0,
    CFG_INNER_K = 2'd1,
    CFG_COLS_M  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_e;

  typedef struct packed {
    logic wr_a;        // write element into left store
    logic wr_b;        // write element into right store
    logic wr_first;    // first element of that matrix
    logic clear;       // reset read address generators
    logic issue;       // one multiply-accumulate step
    logic first;       // first term of a dot product
    logic last_t;      // last term of a dot product
    logic last_j;      // last column of a row
    logic last_entry;  // final entry of the product
  } mme_cmd_t;

  typedef struct packed {
    logic done;        // final entry is on the result ports
  } mme_stat_t;

endpackage

FILE: src/mme_ctrl.sv
// controller: configuration registers, load counting and compute sequencing
module mme_ctrl #(
  parameter int unsigned MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mme_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  mme_pkg::mme_stat_t              stat_i,
  output logic                            busy_o,
  output mme_pkg::mme_cmd_t               cmd_o,
  output logic [$clog2(MAX_DIM)-1:0]      row_o,
  output logic [$clog2(MAX_DIM)-1:0]      col_o,
  output logic [$clog2(MAX_DIM+1)-1:0]    dim_k_o,
  output logic [$clog2(MAX_DIM+1)-1:0]    dim_m_o
);
  import mme_pkg::*;

  localparam int unsigned DW   = $clog2(MAX_DIM);
  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);
  localparam int unsigned LCW  = $clog2(2 * MAX_DIM * MAX_DIM + 1);

  logic [CFG_DATA_W-1:0] rows_q, inner_q, cols_q;
  logic [LCW-1:0]        load_q, load_d;
  ctrl_state_e           state_q, state_d;
  logic [DW-1:0]         t_q, t_d, j_q, j_d, i_q, i_d;
  logic [DIMW-1:0]       dim_n, dim_k, dim_m;
  logic [2*DIMW-1:0]     nk, km;
  logic [LCW-1:0]        a_size, total;
  logic                  cfg_hit;
  logic                  last_t, last_j, last_i;

  function automatic logic [DIMW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] raw);
    logic [CFG_DATA_W:0] wide;
    wide = {1'b0, raw};
    if (raw == '0) begin
      return DIMW'(1);
    end else if (wide > (CFG_DATA_W+1)'(MAX_DIM)) begin
      return DIMW'(MAX_DIM);
    end else begin
      return DIMW'(raw);
    end
  endfunction

  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {CFG_ROWS_N, CFG_INNER_K, CFG_COLS_M});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROWS_N:  rows_q  <= cfg_data_i;
        CFG_INNER_K: inner_q <= cfg_data_i;
        CFG_COLS_M:  cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      load_q  <= '0;
      t_q     <= '0;
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= cfg_hit ? '0 : load_d;
      t_q     <= t_d;
      j_q     <= j_d;
      i_q     <= i_d;
    end
  end

  always_comb begin
    dim_n   = clamp_dim(rows_q);
    dim_k   = clamp_dim(inner_q);
    dim_m   = clamp_dim(cols_q);
    nk      = (2*DIMW)'(dim_n) * (2*DIMW)'(dim_k);
    km      = (2*DIMW)'(dim_k) * (2*DIMW)'(dim_m);
    a_size  = LCW'(nk);
    total   = LCW'(nk) + LCW'(km);
    last_t  = (DIMW'(t_q) + DIMW'(1)) == dim_k;
    last_j  = (DIMW'(j_q) + DIMW'(1)) == dim_m;
    last_i  = (DIMW'(i_q) + DIMW'(1)) == dim_n;

    cmd_o   = '0;
    state_d = state_q;
    load_d  = load_q;
    t_d     = t_q;
    j_d     = j_q;
    i_d     = i_q;

    case (state_q)
      ST_LOAD: begin
        if (start) begin
          cmd_o.wr_a     = load_q < a_size;
          cmd_o.wr_b     = !(load_q < a_size);
          cmd_o.wr_first = (load_q == '0) || (load_q == a_size);
          if ((load_q + LCW'(1)) == total) begin
            load_d      = '0;
            state_d     = ST_RUN;
            cmd_o.clear = 1'b1;
            t_d         = '0;
            j_d         = '0;
            i_d         = '0;
          end else begin
            load_d = load_q + LCW'(1);
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue      = 1'b1;
        cmd_o.first      = t_q == '0;
        cmd_o.last_t     = last_t;
        cmd_o.last_j     = last_j;
        cmd_o.last_entry = last_t && last_j && last_i;
        if (!last_t) begin
          t_d = t_q + DW'(1);
        end else begin
          t_d = '0;
          if (!last_j) begin
            j_d = j_q + DW'(1);
          end else begin
            j_d = '0;
            if (!last_i) begin
              i_d = i_q + DW'(1);
            end else begin
              i_d     = '0;
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (stat_i.done) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign busy_o  = state_q != ST_LOAD;
  assign row_o   = i_q;
  assign col_o   = j_q;
  assign dim_k_o = dim_k;
  assign dim_m_o = dim_m;

endmodule

FILE: src/mme_datapath.sv
// datapath: element stores, address generators, multiplier and accumulator
module mme_datapath #(
  parameter int unsigned MAX_DIM       = mme_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEMENT_WIDTH = mme_pkg::ELEM_W_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mme_pkg::mme_cmd_t                     cmd_i,
  input  logic [$clog2(MAX_DIM)-1:0]            row_i,
  input  logic [$clog2(MAX_DIM)-1:0]            col_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]          dim_k_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]          dim_m_i,
  input  logic signed [ELEMENT_WIDTH-1:0]       element_value_i,
  output mme_pkg::mme_stat_t                    stat_o,
  output logic                                  result_valid_o,
  output logic signed [mme_pkg::PROD_W-1:0]     product_value_o,
  output logic [mme_pkg::IDX_OUT_W-1:0]         out_row_o,
  output logic [mme_pkg::IDX_OUT_W-1:0]         out_col_o,
  output logic                                  last_result_o
);
  import mme_pkg::*;

  localparam int unsigned DW    = $clog2(MAX_DIM);
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = 2 * ELEMENT_WIDTH;
  localparam int unsigned ACC_W = PW + $clog2(MAX_DIM);

  logic signed [ELEMENT_WIDTH-1:0] left_mem  [DEPTH];
  logic signed [ELEMENT_WIDTH-1:0] right_mem [DEPTH];

  logic [AW-1:0]  wr_addr_q, wr_addr;
  logic [AW-1:0]  a_addr_q, b_addr_q, a_base_q, a_base_nxt;
  logic signed [ELEMENT_WIDTH-1:0] a_rd_q, b_rd_q;

  // stage 1: read data, stage 2: product
  logic           s1_v_q, s1_first_q, s1_last_q, s1_fin_q;
  logic [DW-1:0]  s1_row_q, s1_col_q;
  logic           s2_v_q, s2_first_q, s2_last_q, s2_fin_q;
  logic [DW-1:0]  s2_row_q, s2_col_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_sum;

  logic                    res_v_q, res_last_q;
  logic signed [PROD_W-1:0] res_val_q;
  logic [IDX_OUT_W-1:0]    res_row_q, res_col_q;

  assign wr_addr    = cmd_i.wr_first ? '0 : wr_addr_q;
  assign a_base_nxt = a_base_q + AW'(dim_k_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      left_mem[wr_addr] <= element_value_i;
    end
    if (cmd_i.wr_b) begin
      right_mem[wr_addr] <= element_value_i;
    end
    a_rd_q <= left_mem[a_addr_q];
    b_rd_q <= right_mem[b_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_addr_q <= '0;
      a_addr_q  <= '0;
      b_addr_q  <= '0;
      a_base_q  <= '0;
    end else begin
      if (cmd_i.wr_a || cmd_i.wr_b) begin
        wr_addr_q <= wr_addr + AW'(1);
      end
      if (cmd_i.clear) begin
        a_addr_q <= '0;
        b_addr_q <= '0;
        a_base_q <= '0;
      end else if (cmd_i.issue) begin
        if (cmd_i.last_t && cmd_i.last_j) begin
          // next row of A, back to column zero of B
          a_base_q <= a_base_nxt;
          a_addr_q <= a_base_nxt;
          b_addr_q <= '0;
        end else if (cmd_i.last_t) begin
          a_addr_q <= a_base_q;
          b_addr_q <= AW'(col_i) + AW'(1);
        end else begin
          a_addr_q <= a_addr_q + AW'(1);
          b_addr_q <= b_addr_q + AW'(dim_m_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      res_v_q    <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      s1_v_q     <= cmd_i.issue;
      s2_v_q     <= s1_v_q;
      res_v_q    <= s2_v_q && s2_last_q;
      res_last_q <= s2_v_q && s2_last_q && s2_fin_q;
    end
  end

  assign acc_sum = s2_first_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_last_q  <= cmd_i.last_t;
    s1_fin_q   <= cmd_i.last_entry;
    s1_row_q   <= row_i;
    s1_col_q   <= col_i;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_fin_q   <= s1_fin_q;
    s2_row_q   <= s1_row_q;
    s2_col_q   <= s1_col_q;
    prod_q     <= PW'(a_rd_q) * PW'(b_rd_q);
    if (s2_v_q) begin
      acc_q <= acc_sum;
    end
    res_val_q  <= PROD_W'(acc_sum);
    res_row_q  <= IDX_OUT_W'(s2_row_q);
    res_col_q  <= IDX_OUT_W'(s2_col_q);
  end

  assign stat_o.done     = res_v_q && res_last_q;
  assign result_valid_o  = res_v_q;
  assign product_value_o = res_val_q;
  assign out_row_o       = res_row_q;
  assign out_col_o       = res_col_q;
  assign last_result_o   = res_last_q;

endmodule

FILE: src/matrix_multiply_engine_core.sv
// top level of the matrix multiply engine: controller plus datapath
//
// usage
// - set rows_n, inner_k, cols_m through the write port (cfg_we_i, cfg_idx_i,
//   cfg_data_i) while the block is idle; any write to one of them restarts
//   the load, a value of 0 counts as 1 and one above MAX_DIM as MAX_DIM
// - feed elements one per transfer (start high while busy is low), first
//   all N*K elements of A, then all K*M of B, both row-major
// - a load is accepted whenever start is high while busy is low; the last element of B raises busy
// - a single multiply-accumulate unit then walks the product, one term per cycle
// - each entry comes out on result_valid_o for one cycle with its row and
//   column; last_result_o marks the final entry
// - the receiver cannot stall: every result is a transfer in its cycle
// - reset clears the load count and sets all three sizes to 8; the
//   element stores hold nothing defined until loaded
//
module matrix_multiply_engine_core #(
  parameter int unsigned MAX_DIM       = mme_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEMENT_WIDTH = mme_pkg::ELEM_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // element channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ELEMENT_WIDTH-1:0]     element_value_i,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mme_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // result channel
  output logic                                result_valid_o,
  output logic signed [mme_pkg::PROD_W-1:0]   product_value_o,
  output logic [mme_pkg::IDX_OUT_W-1:0]       out_row_o,
  output logic [mme_pkg::IDX_OUT_W-1:0]       out_col_o,
  output logic                                last_result_o
);
  import mme_pkg::*;

  localparam int unsigned DW   = $clog2(MAX_DIM);
  localparam int unsigned DIMW = $clog2(MAX_DIM + 1);

  mme_cmd_t        cmd;
  mme_stat_t       stat;
  logic [DW-1:0]   row_idx, col_idx;
  logic [DIMW-1:0] dim_k, dim_m;

  // sequencing: loads, then the i/j/t walk over the product
  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat),
    .busy_o     (busy),
    .cmd_o      (cmd),
    .row_o      (row_idx),
    .col_o      (col_idx),
    .dim_k_o    (dim_k),
    .dim_m_o    (dim_m)
  );

  // stores, read address generation and the three-stage mac pipeline
  mme_datapath #(
    .MAX_DIM       (MAX_DIM),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .row_i           (row_idx),
    .col_i           (col_idx),
    .dim_k_i         (dim_k),
    .dim_m_i         (dim_m),
    .element_value_i (element_value_i),
    .stat_o          (stat),
    .result_valid_o  (result_valid_o),
    .product_value_o (product_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_result_o   (last_result_o)
  );

endmodule

FILE: src/mme_checker.sv
// port-level checker for the matrix multiply engine, bound to the top level
`include "matrix_multiply_engine_core_defines.svh"

module mme_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic last_result_o
);

  // results only come out during a computation
  `MME_ASSERT_NOW(a_result_while_busy, result_valid_o, busy, "result outside computation")

  // the last flag only rides on a result
  `MME_ASSERT_NOW(a_last_has_strobe, last_result_o, result_valid_o, "last flag without result")

  // the final entry ends the computation
  `MME_ASSERT_NEXT(a_idle_after_last, result_valid_o && last_result_o, !busy,
                   "still busy after final entry")

  // a computation only starts from an element transfer
  `MME_ASSERT_NOW(a_busy_from_load, $rose(busy), $past(start), "busy without a load")

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .last_result_o  (last_result_o)
);

FILE: tb/sv/matrix_multiply_engine_core_test.sv
// self-checking testbench of the matrix multiply engine core with a product tracker class
`timescale 1ns / 1ps

typedef logic signed [mme_pkg::ELEM_W_DEF-1:0] elem_t;

// one product entry as it leaves the block
typedef struct packed {
  logic signed [mme_pkg::PROD_W-1:0] value;
  logic [mme_pkg::IDX_OUT_W-1:0]     row;
  logic [mme_pkg::IDX_OUT_W-1:0]     col;
  logic                              is_last;
} entry_t;

// keeps its own copy of the sizes and both element stores, works out
// the product on the final B element and checks entries in order
class entry_tracker;
  elem_t       left_mem[mme_pkg::MAX_DIM_DEF * mme_pkg::MAX_DIM_DEF];
  elem_t       right_mem[mme_pkg::MAX_DIM_DEF * mme_pkg::MAX_DIM_DEF];
  logic [3:0]  dim_reg[3];
  int unsigned fill;
  entry_t      pending_q[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    for (int r = 0; r < 3; r++) begin
      dim_reg[r] = mme_pkg::DIM_RESET;
    end
    fill    = 0;
    errors  = 0;
    checked = 0;
  endfunction

  // 0 counts as 1, anything above the maximum as the maximum
  function int unsigned dim(int r);
    if (dim_reg[r] < 1) return 1;
    if (dim_reg[r] > mme_pkg::MAX_DIM_DEF) return mme_pkg::MAX_DIM_DEF;
    return dim_reg[r];
  endfunction

  function int unsigned set_size();
    return dim(0) * dim(1) + dim(1) * dim(2);
  endfunction

  function void set_reg(logic [1:0] idx, logic [3:0] val);
    case (idx)
      mme_pkg::CFG_ROWS_N:  dim_reg[0] = val;
      mme_pkg::CFG_INNER_K: dim_reg[1] = val;
      mme_pkg::CFG_COLS_M:  dim_reg[2] = val;
      default: return;
    endcase
    // any size write restarts the load of A
    fill = 0;
  endfunction

  function void take_element(elem_t v);
    int unsigned n, k, m, a_size, total;
    longint acc;
    entry_t e;
    n      = dim(0);
    k      = dim(1);
    m      = dim(2);
    a_size = n * k;
    total  = a_size + k * m;
    if (fill >= total) fill = 0;
    if (fill < a_size) left_mem[fill] = v;
    else right_mem[fill - a_size] = v;
    fill++;
    if (fill < total) return;
    fill = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < m; j++) begin
        acc = 0;
        for (int t = 0; t < k; t++) begin
          acc += longint'(left_mem[i * k + t]) * longint'(right_mem[t * m + j]);
        end
        e.value   = acc[mme_pkg::PROD_W-1:0];
        e.row     = i[mme_pkg::IDX_OUT_W-1:0];
        e.col     = j[mme_pkg::IDX_OUT_W-1:0];
        e.is_last = (i == n - 1) && (j == m - 1);
        pending_q.push_back(e);
      end
    end
  endfunction

  function void compare_entry(logic signed [mme_pkg::PROD_W-1:0] value,
                              logic [mme_pkg::IDX_OUT_W-1:0] row,
                              logic [mme_pkg::IDX_OUT_W-1:0] col,
                              logic is_last);
    entry_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected product entry row %0d col %0d value %0d",
               $time, row, col, value);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    checked++;
    if (value !== e.value) begin
      $display("%0t: product_value expected %0d actual %0d", $time, e.value, value);
      errors++;
    end
    if (row !== e.row) begin
      $display("%0t: out_row expected %0d actual %0d", $time, e.row, row);
      errors++;
    end
    if (col !== e.col) begin
      $display("%0t: out_col expected %0d actual %0d", $time, e.col, col);
      errors++;
    end
    if (is_last !== e.is_last) begin
      $display("%0t: last_result expected %0b actual %0b", $time, e.is_last, is_last);
      errors++;
    end
  endfunction
endclass

module matrix_multiply_engine_core_test;

  localparam int unsigned   ITEM_TARGET = 460;
  localparam int unsigned   QUIET_FROM  = 400;     // sender idling stops here
  localparam int unsigned   DRAIN_PAD   = 6;       // cycles after busy falls
  localparam int unsigned   CYCLE_LIMIT = 200000;
  localparam logic [1:0]    CFG_SPARE   = 2'd3;    // index with no register behind it
  localparam elem_t         ELEM_MIN    = 16'sh8000;
  localparam elem_t         ELEM_MAX    = 16'sh7fff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // element channel
  logic  start           = 1'b0;
  logic  busy;
  elem_t element_value_i = '0;

  // configuration write port
  logic                            cfg_we_i   = 1'b0;
  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_idx_i  = '0;
  logic [mme_pkg::CFG_DATA_W-1:0]  cfg_data_i = '0;

  // result channel
  logic                                result_valid_o;
  logic signed [mme_pkg::PROD_W-1:0]   product_value_o;
  logic [mme_pkg::IDX_OUT_W-1:0]       out_row_o;
  logic [mme_pkg::IDX_OUT_W-1:0]       out_col_o;
  logic                                last_result_o;

  entry_tracker tracker = new();

  elem_t       load_q[$];          // elements of the next load, in transfer order
  bit          quiet = 1'b0;       // no sender idling once set
  int unsigned elements_sent = 0;
  int unsigned pairs_done    = 0;
  int unsigned aborted_loads = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycles        = 0;

  matrix_multiply_engine_core dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .element_value_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .result_valid_o,
    .product_value_o,
    .out_row_o,
    .out_col_o,
    .last_result_o
  );

  always #5 clk_i = ~clk_i;

  // hard stop in case the block hangs or loses results
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d entries outstanding",
               $time, cycles, tracker.pending_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // every strobed result is a transfer, the receiver never holds off;
  // outputs read right after the edge still hold the values of the cycle it ends
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      tracker.compare_entry(product_value_o, out_row_o, out_col_o, last_result_o);
    end
  end

  // random sender idling before about one transfer in four
  function automatic int unsigned idle_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 5);
  endfunction

  // extremes and small values show up often, the rest is any 16-bit pattern
  function automatic elem_t pick_element();
    case ($urandom_range(0, 7))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return -1;
      default: return elem_t'($urandom);
    endcase
  endfunction

  // mostly small sizes, sometimes anything the 4-bit register holds
  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 3) != 0) return 4'($urandom_range(1, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  // one element transfer: start stays high when the next one follows at once,
  // so it is never lowered and raised in the same step
  task automatic send_element(elem_t v);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    element_value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.take_element(v);
    elements_sent++;
  endtask

  task automatic load_queue();
    while (load_q.size() != 0) send_element(load_q.pop_front());
    start <= 1'b0;
  endtask

  // write enable is left high so back-to-back writes need one assignment per step
  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
    reg_writes++;
  endtask

  task automatic write_dims(logic [3:0] n, logic [3:0] k, logic [3:0] m);
    write_reg(mme_pkg::CFG_ROWS_N, n);
    write_reg(mme_pkg::CFG_INNER_K, k);
    write_reg(mme_pkg::CFG_COLS_M, m);
    cfg_we_i <= 1'b0;
  endtask

  // all entries back, compute finished, then a quiet pad before the next step
  task automatic wait_drained();
    while (tracker.pending_q.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic full_pair();
    repeat (tracker.set_size()) load_q.push_back(pick_element());
    load_queue();
    wait_drained();
    pairs_done++;
  endtask

  initial begin
    int unsigned directed_sent;
    int unsigned total;
    int unsigned choice;
    bit          must_write;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    // a partial load at the reset sizes, dropped by the size write after it
    load_q = '{16'sh0123, ELEM_MIN, ELEM_MAX};
    load_queue();
    wait_drained();
    aborted_loads++;
    // a write to the unused index must leave everything alone
    write_reg(CFG_SPARE, 4'hf);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);

    // 1x1x1: extreme products one pair at a time
    write_dims(4'd1, 4'd1, 4'd1);
    load_q = '{ELEM_MIN, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MAX, -16'sd1, 16'sd1};
    load_queue();
    wait_drained();
    pairs_done += 4;

    // zero sizes count as one
    write_dims(4'd0, 4'd1, 4'd0);
    load_q = '{16'sh0100, 16'sh0100};
    load_queue();
    wait_drained();
    pairs_done++;

    // two products of the most negative elements summed
    write_dims(4'd1, 4'd2, 4'd1);
    load_q = '{ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN};
    load_queue();
    wait_drained();
    pairs_done++;

    // outer product of mixed extremes, checks row and column order
    write_dims(4'd2, 4'd1, 4'd2);
    load_q = '{ELEM_MAX, ELEM_MIN, ELEM_MIN, ELEM_MAX};
    load_queue();
    wait_drained();
    pairs_done++;
    directed_sent = elements_sent;

    // random part
    // longest dot product with every term at its largest, inner size above range
    write_dims(4'd1, 4'd15, 4'd1);
    repeat (tracker.set_size()) load_q.push_back(ELEM_MIN);
    load_queue();
    wait_drained();
    pairs_done++;

    // largest sizes through clamped register values
    write_dims(4'd9, 4'd8, 4'd15);
    full_pair();

    must_write = 1'b1;
    while (elements_sent - directed_sent < ITEM_TARGET) begin
      quiet  = (elements_sent - directed_sent >= QUIET_FROM);
      choice = $urandom_range(0, 9);
      if (choice == 2) begin
        write_reg(CFG_SPARE, 4'($urandom));
        cfg_we_i <= 1'b0;
        @(posedge clk_i);
      end
      // choice 0 keeps the sizes and loads the next pair straight away
      if (must_write || choice != 0) write_dims(pick_dim(), pick_dim(), pick_dim());
      must_write = 1'b0;
      total = tracker.set_size();
      if (choice == 1 && total > 1) begin
        // broken load: stop part way, the next size write starts over
        repeat ($urandom_range(1, total - 1)) load_q.push_back(pick_element());
        load_queue();
        wait_drained();
        aborted_loads++;
        must_write = 1'b1;
      end else begin
        full_pair();
      end
    end

    start <= 1'b0;
    wait_drained();

    if (tracker.pending_q.size() != 0) begin
      $display("%0t: %0d product entries never arrived", $time, tracker.pending_q.size());
      tracker.errors += tracker.pending_q.size();
    end

    $display("summary: %0d element transfers, %0d matrix pairs, %0d aborted loads",
             elements_sent, pairs_done, aborted_loads);
    $display("summary: %0d register writes, %0d product entries checked, %0d errors",
             reg_writes, tracker.checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
